>>> hw/rtl/stdt_pkg.sv
// Shared types and constants for the stack trace dedup table.
// No dependencies; used by stdt_bucket_mod and stack_trace_dedup_table.
`timescale 1ns / 1ps

package stdt_pkg;

    localparam int HASH_W   = 32;
    localparam int DEPTH_W  = 7;
    localparam int FRAME_W  = 64;
    localparam int SIZE_W   = 64;
    localparam int HITS_W   = 32;
    localparam int ID_W     = 12;
    localparam int STATUS_W = 2;

    localparam int IN_DATA_W  = 232;
    localparam int OUT_DATA_W = 112;

    localparam int MOD_CYCLES = 3;
    localparam int MOD_CNT_W  = $clog2(MOD_CYCLES);

    localparam int BUCKETS_DEF     = 256;
    localparam int MAX_ENTRIES_DEF = 4096;

    localparam logic CMD_INSERT = 1'b0;
    localparam logic CMD_LOOKUP = 1'b1;

    typedef enum logic [STATUS_W-1:0] {
        STAT_MATCH = 2'd0,
        STAT_NEW   = 2'd1,
        STAT_FULL  = 2'd2,
        STAT_MISS  = 2'd3
    } status_t;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_MOD,
        ST_HEAD_RD,
        ST_HEAD_CAP,
        ST_PROBE,
        ST_CMP,
        ST_EMIT
    } state_t;

endpackage

>>> hw/rtl/stdt_bucket_mod.sv
// Remainder of the key hash by the bucket count through reciprocal
// multiplication and one correcting subtract.
// Depends on stdt_pkg.
`timescale 1ns / 1ps

module stdt_bucket_mod #(
    parameter int BUCKETS = stdt_pkg::BUCKETS_DEF,
    parameter int BW      = (BUCKETS > 1) ? $clog2(BUCKETS) : 1
) (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       start,
    input  logic [stdt_pkg::HASH_W-1:0] hash,
    output logic                       done,
    output logic [BW-1:0]              bucket
);

    localparam int          KW    = $clog2(BUCKETS);
    localparam int          SHIFT = 31 + KW;
    localparam logic [31:0] RECIP = 32'((64'd1 << SHIFT) / 64'(BUCKETS));

    logic                           busy_reg, busy_next;
    logic [stdt_pkg::MOD_CNT_W-1:0] cnt_reg, cnt_next;
    logic [stdt_pkg::HASH_W-1:0]    h_reg, h_next;
    logic [63:0]                    prod_reg, prod_next;
    logic [stdt_pkg::HASH_W-1:0]    qb_reg, qb_next;
    logic [BW-1:0]                  rem_reg, rem_next;
    logic [stdt_pkg::HASH_W-1:0]    q_est;
    logic [stdt_pkg::HASH_W-1:0]    diff;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
        end
        h_reg    <= h_next;
        prod_reg <= prod_next;
        qb_reg   <= qb_next;
        rem_reg  <= rem_next;
    end

    always_comb begin
        prod_next = 64'(h_reg) * 64'(RECIP);
        q_est     = 32'(prod_reg >> SHIFT);
        qb_next   = q_est * stdt_pkg::HASH_W'(BUCKETS);
        diff      = h_reg - qb_reg;
        if (diff >= stdt_pkg::HASH_W'(BUCKETS)) begin
            rem_next = BW'(diff - stdt_pkg::HASH_W'(BUCKETS));
        end else begin
            rem_next = BW'(diff);
        end
    end

    always_comb begin
        done      = busy_reg &&
                    (cnt_reg == stdt_pkg::MOD_CNT_W'(stdt_pkg::MOD_CYCLES - 1));
        busy_next = busy_reg;
        cnt_next  = cnt_reg;
        h_next    = h_reg;
        if (start) begin
            busy_next = 1'b1;
            cnt_next  = '0;
            h_next    = hash;
        end else if (busy_reg) begin
            cnt_next = cnt_reg + 1'b1;
            if (done) begin
                busy_next = 1'b0;
            end
        end
    end

    assign bucket = rem_reg;

endmodule

>>> hw/rtl/stack_trace_dedup_table.sv
// Stack trace dedup table: chained hash table with hit counts and size sums.
// Depends on stdt_pkg and stdt_bucket_mod.
//
//  channel | dir | contents
//  s_      | in  | tuser: command; tdata: key_hash, key_depth, first_frame,
//          |     |        second_frame, alloc_size
//  m_      | out | tuser: status; tdata: stack_id, hit_count, size_total
//
// A request passes from accept to m_tvalid through the bucket remainder, the bucket
// head read and capture, a probe and a compare for each chain entry walked, one
// more probe that ends the walk on a miss (and writes a new entry on an insert with
// room), and the handover of the result; s_tready returns together with m_tvalid.
// After reset all BUCKETS bucket heads are cleared one per cycle; s_tready stays
// low meanwhile. A result held by m_tready low does not block the next request;
// only its handover waits.
`timescale 1ns / 1ps

module stack_trace_dedup_table #(
    parameter int BUCKETS     = stdt_pkg::BUCKETS_DEF,
    parameter int MAX_ENTRIES = stdt_pkg::MAX_ENTRIES_DEF
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    // key_hash, key_depth, first_frame, second_frame, alloc_size
    input  logic [stdt_pkg::IN_DATA_W-1:0]  s_tdata,
    // command
    input  logic                            s_tuser,
    output logic                            m_tvalid,
    input  logic                            m_tready,
    // stack_id, hit_count, size_total
    output logic [stdt_pkg::OUT_DATA_W-1:0] m_tdata,
    // status
    output logic [stdt_pkg::STATUS_W-1:0]   m_tuser
);

    localparam int BW = (BUCKETS > 1) ? $clog2(BUCKETS) : 1;
    localparam int IW = $clog2(MAX_ENTRIES);
    localparam int LW = $clog2(MAX_ENTRIES + 1);
    localparam logic [LW-1:0] NO_LINK = LW'(MAX_ENTRIES);

    typedef struct packed {
        logic [LW-1:0]                  next;
        logic [stdt_pkg::HASH_W-1:0]    hash;
        logic [stdt_pkg::DEPTH_W-1:0]   depth;
        logic [stdt_pkg::FRAME_W-1:0]   frame_a;
        logic [stdt_pkg::FRAME_W-1:0]   frame_b;
        logic [stdt_pkg::HITS_W-1:0]    hits;
        logic [stdt_pkg::SIZE_W-1:0]    size_sum;
    } entry_t;

    logic [LW-1:0] head_mem [BUCKETS];
    entry_t        ent_mem  [MAX_ENTRIES];

    stdt_pkg::state_t state_reg, state_next;
    logic [BW-1:0]    clr_reg, clr_next;
    logic [LW-1:0]    used_reg, used_next;
    logic [LW-1:0]    cur_reg, cur_next;
    logic [LW-1:0]    head_reg, head_next;

    logic                            cmd_reg, cmd_next;
    logic [stdt_pkg::HASH_W-1:0]     hash_reg, hash_next;
    logic [stdt_pkg::DEPTH_W-1:0]    depth_reg, depth_next;
    logic [stdt_pkg::FRAME_W-1:0]    fa_reg, fa_next;
    logic [stdt_pkg::FRAME_W-1:0]    fb_reg, fb_next;
    logic [stdt_pkg::SIZE_W-1:0]     size_reg, size_next;

    logic [stdt_pkg::ID_W-1:0]       res_id_reg, res_id_next;
    stdt_pkg::status_t               res_stat_reg, res_stat_next;
    logic [stdt_pkg::HITS_W-1:0]     res_hits_reg, res_hits_next;
    logic [stdt_pkg::SIZE_W-1:0]     res_sum_reg, res_sum_next;

    logic                            m_tvalid_reg, m_tvalid_next;
    logic [stdt_pkg::ID_W-1:0]       out_id_reg, out_id_next;
    stdt_pkg::status_t               out_stat_reg, out_stat_next;
    logic [stdt_pkg::HITS_W-1:0]     out_hits_reg, out_hits_next;
    logic [stdt_pkg::SIZE_W-1:0]     out_sum_reg, out_sum_next;

    logic          head_we;
    logic [BW-1:0] head_waddr;
    logic [LW-1:0] head_wdata;
    logic [LW-1:0] head_q;
    logic          ent_we;
    logic [IW-1:0] ent_waddr;
    entry_t        ent_wdata;
    entry_t        ent_q;

    logic          mod_start;
    logic          mod_done;
    logic [BW-1:0] bucket;
    logic          s_acc;
    logic          key_eq;
    logic          new_ins;

    stdt_bucket_mod #(
        .BUCKETS (BUCKETS),
        .BW      (BW)
    ) u_mod (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (mod_start),
        .hash    (s_tdata[31:0]),
        .done    (mod_done),
        .bucket  (bucket)
    );

    always_ff @(posedge aclk) begin
        if (head_we) begin
            head_mem[head_waddr] <= head_wdata;
        end
        head_q <= head_mem[bucket];
    end

    always_ff @(posedge aclk) begin
        if (ent_we) begin
            ent_mem[ent_waddr] <= ent_wdata;
        end
        ent_q <= ent_mem[cur_reg[IW-1:0]];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= stdt_pkg::ST_CLEAR;
            clr_reg      <= '0;
            used_reg     <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            clr_reg      <= clr_next;
            used_reg     <= used_next;
            m_tvalid_reg <= m_tvalid_next;
        end
        cur_reg      <= cur_next;
        head_reg     <= head_next;
        cmd_reg      <= cmd_next;
        hash_reg     <= hash_next;
        depth_reg    <= depth_next;
        fa_reg       <= fa_next;
        fb_reg       <= fb_next;
        size_reg     <= size_next;
        res_id_reg   <= res_id_next;
        res_stat_reg <= res_stat_next;
        res_hits_reg <= res_hits_next;
        res_sum_reg  <= res_sum_next;
        out_id_reg   <= out_id_next;
        out_stat_reg <= out_stat_next;
        out_hits_reg <= out_hits_next;
        out_sum_reg  <= out_sum_next;
    end

    assign s_acc  = s_tvalid && s_tready;
    assign key_eq = (ent_q.hash == hash_reg) && (ent_q.depth == depth_reg) &&
                    (ent_q.frame_a == fa_reg) && (ent_q.frame_b == fb_reg);

    always_comb begin
        state_next    = state_reg;
        clr_next      = clr_reg;
        used_next     = used_reg;
        cur_next      = cur_reg;
        head_next     = head_reg;
        cmd_next      = cmd_reg;
        hash_next     = hash_reg;
        depth_next    = depth_reg;
        fa_next       = fa_reg;
        fb_next       = fb_reg;
        size_next     = size_reg;
        res_id_next   = res_id_reg;
        res_stat_next = res_stat_reg;
        res_hits_next = res_hits_reg;
        res_sum_next  = res_sum_reg;
        m_tvalid_next = m_tvalid_reg && !m_tready;
        out_id_next   = out_id_reg;
        out_stat_next = out_stat_reg;
        out_hits_next = out_hits_reg;
        out_sum_next  = out_sum_reg;
        s_tready      = 1'b0;
        mod_start     = 1'b0;
        head_we       = 1'b0;
        head_waddr    = bucket;
        head_wdata    = NO_LINK;
        ent_we        = 1'b0;
        ent_waddr     = cur_reg[IW-1:0];
        ent_wdata     = ent_q;
        new_ins       = 1'b0;

        unique case (state_reg)
            stdt_pkg::ST_CLEAR: begin
                head_we    = 1'b1;
                head_waddr = clr_reg;
                clr_next   = clr_reg + 1'b1;
                if (clr_reg == BW'(BUCKETS - 1)) begin
                    state_next = stdt_pkg::ST_IDLE;
                end
            end
            stdt_pkg::ST_IDLE: begin
                s_tready = 1'b1;
                if (s_acc) begin
                    mod_start  = 1'b1;
                    cmd_next   = s_tuser;
                    hash_next  = s_tdata[31:0];
                    depth_next = s_tdata[38:32];
                    fa_next    = s_tdata[102:39];
                    fb_next    = s_tdata[166:103];
                    size_next  = s_tdata[230:167];
                    state_next = stdt_pkg::ST_MOD;
                end
            end
            stdt_pkg::ST_MOD: begin
                if (mod_done) begin
                    state_next = stdt_pkg::ST_HEAD_RD;
                end
            end
            stdt_pkg::ST_HEAD_RD: begin
                state_next = stdt_pkg::ST_HEAD_CAP;
            end
            stdt_pkg::ST_HEAD_CAP: begin
                cur_next   = head_q;
                head_next  = head_q;
                state_next = stdt_pkg::ST_PROBE;
            end
            stdt_pkg::ST_PROBE: begin
                if (cur_reg != NO_LINK) begin
                    state_next = stdt_pkg::ST_CMP;
                end else begin
                    state_next    = stdt_pkg::ST_EMIT;
                    res_id_next   = '0;
                    res_hits_next = '0;
                    res_sum_next  = '0;
                    if (cmd_reg == stdt_pkg::CMD_LOOKUP) begin
                        res_stat_next = stdt_pkg::STAT_MISS;
                    end else if (used_reg == NO_LINK) begin
                        res_stat_next = stdt_pkg::STAT_FULL;
                    end else begin
                        new_ins            = 1'b1;
                        ent_we             = 1'b1;
                        ent_waddr          = used_reg[IW-1:0];
                        ent_wdata.next     = head_reg;
                        ent_wdata.hash     = hash_reg;
                        ent_wdata.depth    = depth_reg;
                        ent_wdata.frame_a  = fa_reg;
                        ent_wdata.frame_b  = fb_reg;
                        ent_wdata.hits     = stdt_pkg::HITS_W'(1);
                        ent_wdata.size_sum = size_reg;
                        head_we            = 1'b1;
                        head_wdata         = used_reg;
                        used_next          = used_reg + 1'b1;
                        res_id_next        = stdt_pkg::ID_W'(used_reg);
                        res_stat_next      = stdt_pkg::STAT_NEW;
                        res_hits_next      = stdt_pkg::HITS_W'(1);
                        res_sum_next       = size_reg;
                    end
                end
            end
            stdt_pkg::ST_CMP: begin
                if (key_eq) begin
                    state_next    = stdt_pkg::ST_EMIT;
                    res_id_next   = stdt_pkg::ID_W'(cur_reg);
                    res_stat_next = stdt_pkg::STAT_MATCH;
                    if (cmd_reg == stdt_pkg::CMD_INSERT) begin
                        if (ent_q.hits != '1) begin
                            ent_wdata.hits = ent_q.hits + 1'b1;
                        end
                        ent_wdata.size_sum = ent_q.size_sum + size_reg;
                        ent_we             = 1'b1;
                    end
                    res_hits_next = ent_wdata.hits;
                    res_sum_next  = ent_wdata.size_sum;
                end else begin
                    cur_next   = ent_q.next;
                    state_next = stdt_pkg::ST_PROBE;
                end
            end
            stdt_pkg::ST_EMIT: begin
                if (!m_tvalid_reg || m_tready) begin
                    m_tvalid_next = 1'b1;
                    out_id_next   = res_id_reg;
                    out_stat_next = res_stat_reg;
                    out_hits_next = res_hits_reg;
                    out_sum_next  = res_sum_reg;
                    state_next    = stdt_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = stdt_pkg::ST_IDLE;
            end
        endcase
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tuser  = out_stat_reg;
    assign m_tdata  = {4'b0, out_sum_reg, out_hits_reg, out_id_reg};

    a_used_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        used_reg <= NO_LINK)
        else $error("entry count beyond capacity");

    a_new_advances: assert property (@(posedge aclk) disable iff (!aresetn)
        new_ins |=> used_reg == $past(used_reg) + 1'b1)
        else $error("new entry did not advance the entry count");

    a_empty_result: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (m_tuser == stdt_pkg::STAT_FULL || m_tuser == stdt_pkg::STAT_MISS)
        |-> (out_id_reg == '0 && out_hits_reg == '0 && out_sum_reg == '0))
        else $error("empty result carries entry data");

endmodule
